### rtl/mma_pkg.sv
package mma_pkg;

  localparam int CHAN_W   = 3;
  localparam int SAMPLE_W = 12;

  // tag that travels with a beat down the pipeline
  typedef struct packed {
    logic [CHAN_W-1:0] chan;
    logic              in_range;
  } mma_tag_t;

endpackage

### rtl/multichannel_moving_average.sv
// pipeline: an accepted beat passes the stage-one register (with its ring read), the
// divider input register and the output register; a stall can hold it in any of them
// throughput: one beat per cycle, any mix of channels, while out_stall is low and no
// clearing pass runs; the ring memory takes one read and one write each cycle
// reset: synchronous, clears the pipeline, write positions and running sums, then
// a clearing pass zeroes all NUM_CHANNELS*WINDOW_LEN ring entries (120 by default),
// with in_stall held high throughout
module multichannel_moving_average
  import mma_pkg::*;
#(
  parameter int WINDOW_LEN   = 15,
  parameter int NUM_CHANNELS = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [CHAN_W-1:0]   in_chan_sel,
  input  logic [SAMPLE_W-1:0] in_sample_in,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [CHAN_W-1:0]   out_chan_out,
  output logic [SAMPLE_W-1:0] out_avg_out
);

  localparam int POS_W  = $clog2(WINDOW_LEN);
  localparam int SUM_W  = SAMPLE_W + $clog2(WINDOW_LEN);
  localparam int CH_IW  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int DEPTH  = NUM_CHANNELS * WINDOW_LEN;
  localparam int ADDR_W = $clog2(DEPTH);

  logic              clr_active_r;
  logic [ADDR_W-1:0] clr_addr_r;

  logic [POS_W-1:0]  pos_r [NUM_CHANNELS];
  logic [SUM_W-1:0]  sum_r [NUM_CHANNELS];

  logic                in_acc;
  logic                in_range;
  logic [CH_IW-1:0]    in_idx;
  logic [POS_W-1:0]    cur_pos;
  logic [POS_W-1:0]    pos_inc;
  logic [ADDR_W-1:0]   rd_addr;
  mma_tag_t            in_tag;

  logic                s1_v_r;
  mma_tag_t            s1_tag_r;
  logic [SAMPLE_W-1:0] s1_smp_r;
  logic [ADDR_W-1:0]   s1_addr_r;
  logic [CH_IW-1:0]    s1_idx;
  logic                s1_adv;
  logic                s1_free;
  logic                s2_ready;
  logic [SAMPLE_W-1:0] old_smp;
  logic [SUM_W-1:0]    new_sum;

  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr;
  logic [SAMPLE_W-1:0] ram_wdata;

  assign in_idx   = CH_IW'(in_chan_sel);
  assign in_range = 32'(in_chan_sel) < NUM_CHANNELS;
  assign in_acc   = in_valid && !in_stall;
  assign cur_pos  = pos_r[in_idx];
  assign pos_inc  = (cur_pos == POS_W'(WINDOW_LEN - 1)) ? '0 : cur_pos + 1'b1;
  assign rd_addr  = ADDR_W'(int'(in_idx) * WINDOW_LEN + int'(cur_pos));
  assign in_tag   = '{chan: in_chan_sel, in_range: in_range};

  assign s1_free  = !s1_v_r || s2_ready;
  assign s1_adv   = s1_v_r && s2_ready;
  assign in_stall = clr_active_r || !s1_free;

  // same-channel beats in flight never touch the same ring entry, so the
  // running sum is the only state that needs to be current in stage one
  assign s1_idx  = CH_IW'(s1_tag_r.chan);
  assign new_sum = sum_r[s1_idx] - SUM_W'(old_smp) + SUM_W'(s1_smp_r);

  assign ram_we    = clr_active_r || (s1_adv && s1_tag_r.in_range);
  assign ram_waddr = clr_active_r ? clr_addr_r : s1_addr_r;
  assign ram_wdata = clr_active_r ? '0 : s1_smp_r;

  mma_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (in_acc && in_range),
    .raddr (rd_addr),
    .rdata (old_smp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_addr_r   <= '0;
      s1_v_r       <= 1'b0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        pos_r[i] <= '0;
        sum_r[i] <= '0;
      end
    end else begin
      if (clr_active_r) begin
        clr_addr_r <= clr_addr_r + 1'b1;
        if (clr_addr_r == ADDR_W'(DEPTH - 1)) begin
          clr_active_r <= 1'b0;
        end
      end
      if (s1_free) begin
        s1_v_r <= in_acc;
      end
      if (in_acc && in_range) begin
        pos_r[in_idx] <= pos_inc;
      end
      if (s1_adv && s1_tag_r.in_range) begin
        sum_r[s1_idx] <= new_sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_tag_r  <= in_tag;
      s1_smp_r  <= in_sample_in;
      s1_addr_r <= rd_addr;
    end
  end

  mma_div_stage #(
    .WINDOW_LEN (WINDOW_LEN),
    .SUM_W      (SUM_W)
  ) u_div (
    .clk          (clk),
    .rst_n        (rst_n),
    .s2_valid     (s1_v_r),
    .s2_ready     (s2_ready),
    .s2_tag       (s1_tag_r),
    .s2_sum       (s1_tag_r.in_range ? new_sum : '0),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_chan_out (out_chan_out),
    .out_avg_out  (out_avg_out)
  );

endmodule

### rtl/mma_ram.sv
module mma_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 120
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/mma_div_stage.sv
module mma_div_stage
  import mma_pkg::*;
#(
  parameter int WINDOW_LEN = 15,
  parameter int SUM_W      = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                s2_valid,
  output logic                s2_ready,
  input  mma_tag_t            s2_tag,
  input  logic [SUM_W-1:0]    s2_sum,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [CHAN_W-1:0]   out_chan_out,
  output logic [SAMPLE_W-1:0] out_avg_out
);

  // division by the window length as a multiply by a rounded-up reciprocal
  localparam int LOG_W  = $clog2(WINDOW_LEN);
  localparam int K      = SUM_W + LOG_W;
  localparam int M_W    = SUM_W + 2;
  localparam int PROD_W = SUM_W + M_W;
  localparam longint unsigned RECIP = ((64'd1 << K) + WINDOW_LEN - 1) / WINDOW_LEN;

  logic                v_r;
  mma_tag_t            tag_r;
  logic [SUM_W-1:0]    sum_r;
  logic                out_v_r;
  logic [CHAN_W-1:0]   chan_r;
  logic [SAMPLE_W-1:0] avg_r;
  logic                out_ready;
  logic                v_adv;
  logic [M_W-1:0]      recip;
  logic [PROD_W-1:0]   prod;
  logic [SAMPLE_W-1:0] quot;

  assign out_ready = !out_v_r || !out_stall;
  assign v_adv     = v_r && out_ready;
  assign s2_ready  = !v_r || out_ready;

  assign recip = M_W'(RECIP);
  assign prod  = {{M_W{1'b0}}, sum_r} * {{SUM_W{1'b0}}, recip};
  assign quot  = prod[K +: SAMPLE_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r     <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (s2_ready) begin
        v_r <= s2_valid;
      end
      if (out_ready) begin
        out_v_r <= v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s2_valid) begin
      tag_r <= s2_tag;
      sum_r <= s2_sum;
    end
    if (v_adv) begin
      chan_r <= tag_r.chan;
      avg_r  <= tag_r.in_range ? quot : '0;
    end
  end

  assign out_valid    = out_v_r;
  assign out_chan_out = chan_r;
  assign out_avg_out  = avg_r;

endmodule

### rtl/mma_checker.sv
module mma_checker
  import mma_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input logic [CHAN_W-1:0]   out_chan_out,
  input logic [SAMPLE_W-1:0] out_avg_out
);

  // ring clearing holds off input straight after reset
  assert property (@(posedge clk) !rst_n |=> in_stall)
    else $error("input not held off after reset");

  // reset empties the pipeline
  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output beat present after reset");

  // a stalled output beat stays put
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=>
      out_valid && $stable(out_chan_out) && $stable(out_avg_out))
    else $error("stalled output beat changed");

  // an output beat always carries a defined payload
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !$isunknown({out_chan_out, out_avg_out}))
    else $error("output beat with undefined payload");

endmodule

bind multichannel_moving_average mma_checker u_mma_checker (.*);
